[rtl/dd_pkg.sv]
package dd_pkg;

	// sizes
	localparam int NUM_PROCESSES = 8;
	localparam int NUM_RESOURCES = 3;
	localparam int DATA_W        = 8;
	localparam int WORK_W        = 11;
	localparam int ID_W          = $clog2(NUM_PROCESSES);
	localparam int CNT_W         = $clog2(NUM_PROCESSES + 1);
	localparam int CFG_IDX_W     = 2;

	localparam logic [WORK_W-1:0] WORK_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AVAIL_RES0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AVAIL_RES1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AVAIL_RES2 = 2'd2;

	// reset values of the available vector
	localparam logic [DATA_W-1:0] AVAIL_RES0_RST = 8'd7;
	localparam logic [DATA_W-1:0] AVAIL_RES1_RST = 8'd8;
	localparam logic [DATA_W-1:0] AVAIL_RES2_RST = 8'd6;

	typedef logic [NUM_RESOURCES-1:0][DATA_W-1:0] res_vec_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic scan;
	} dd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic            hit;
		logic            last_hit;
		logic            pass_end;
		logic            all_done;
		logic [ID_W-1:0] id;
	} dd_status_t;

endpackage

[rtl/dd_datapath.sv]
module dd_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dd_pkg::dd_cmd_t              cmd,
	input  dd_pkg::res_vec_t             row_alloc,
	input  dd_pkg::res_vec_t             row_req,
	input  logic                         cfg_we,
	input  logic [dd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [dd_pkg::DATA_W-1:0]    cfg_wdata,
	output dd_pkg::dd_status_t           status
);

	dd_pkg::res_vec_t avail_q;
	dd_pkg::res_vec_t alloc_q [dd_pkg::NUM_PROCESSES];
	dd_pkg::res_vec_t req_q [dd_pkg::NUM_PROCESSES];
	logic [dd_pkg::WORK_W-1:0] work_q [dd_pkg::NUM_RESOURCES];
	logic [dd_pkg::NUM_PROCESSES-1:0] fin_q;
	logic [dd_pkg::CNT_W-1:0] rows_q;
	logic [dd_pkg::CNT_W-1:0] n_q;
	logic [dd_pkg::CNT_W-1:0] done_q;
	logic [dd_pkg::CNT_W-1:0] idx_q;

	logic                        room;
	logic [dd_pkg::CNT_W-1:0]    rows_next;
	logic [dd_pkg::CNT_W-1:0]    done_inc;
	logic [dd_pkg::ID_W-1:0]     cur_id;
	logic                        in_range;
	logic                        fits_all;
	logic [dd_pkg::WORK_W:0]     sum [dd_pkg::NUM_RESOURCES];
	logic [dd_pkg::WORK_W-1:0]   sat [dd_pkg::NUM_RESOURCES];
	logic                        hit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q[0] <= dd_pkg::AVAIL_RES0_RST;
			avail_q[1] <= dd_pkg::AVAIL_RES1_RST;
			avail_q[2] <= dd_pkg::AVAIL_RES2_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				dd_pkg::REG_AVAIL_RES0: avail_q[0] <= cfg_wdata;
				dd_pkg::REG_AVAIL_RES1: avail_q[1] <= cfg_wdata;
				dd_pkg::REG_AVAIL_RES2: avail_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// row load bookkeeping
	assign room      = rows_q < dd_pkg::CNT_W'(dd_pkg::NUM_PROCESSES);
	assign rows_next = room ? rows_q + dd_pkg::CNT_W'(1) : rows_q;
	assign done_inc  = done_q + dd_pkg::CNT_W'(1);

	// process tables, rows beyond the bound are dropped
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			alloc_q[rows_q[dd_pkg::ID_W-1:0]] <= row_alloc;
			req_q[rows_q[dd_pkg::ID_W-1:0]]   <= row_req;
		end
	end

	// examine the row under the scan pointer
	assign cur_id   = idx_q[dd_pkg::ID_W-1:0];
	assign in_range = idx_q < n_q;

	always_comb begin
		fits_all = 1'b1;
		for (int r = 0; r < dd_pkg::NUM_RESOURCES; r++) begin
			if (dd_pkg::WORK_W'(req_q[cur_id][r]) > work_q[r])
				fits_all = 1'b0;
			sum[r] = {1'b0, work_q[r]} + (dd_pkg::WORK_W + 1)'(alloc_q[cur_id][r]);
			sat[r] = sum[r][dd_pkg::WORK_W] ? dd_pkg::WORK_MAX : sum[r][dd_pkg::WORK_W-1:0];
		end
	end

	assign hit = in_range && !fin_q[cur_id] && fits_all;

	// run state: work vector, finish marks, counters and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < dd_pkg::NUM_RESOURCES; r++)
				work_q[r] <= '0;
			fin_q  <= '0;
			rows_q <= '0;
			n_q    <= '0;
			done_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.load && !cmd.start)
				rows_q <= rows_next;
			if (cmd.start) begin
				rows_q <= '0;
				n_q    <= rows_next;
				for (int r = 0; r < dd_pkg::NUM_RESOURCES; r++)
					work_q[r] <= dd_pkg::WORK_W'(avail_q[r]);
				fin_q  <= '0;
				done_q <= '0;
				idx_q  <= '0;
			end else if (cmd.scan) begin
				if (hit) begin
					for (int r = 0; r < dd_pkg::NUM_RESOURCES; r++)
						work_q[r] <= sat[r];
					fin_q[cur_id] <= 1'b1;
					done_q <= done_inc;
					idx_q  <= '0;
				end else if (in_range) begin
					idx_q <= idx_q + dd_pkg::CNT_W'(1);
				end
			end
		end
	end

	assign status.hit      = hit;
	assign status.last_hit = hit && (done_inc == n_q);
	assign status.pass_end = !in_range;
	assign status.all_done = done_q == n_q;
	assign status.id       = cur_id;

	// finished count never passes the number of loaded rows
	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= n_q)
		else $error("finished count above row count");

	// a run never covers more rows than the table holds
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= dd_pkg::CNT_W'(dd_pkg::NUM_PROCESSES))
		else $error("row count above table size");

endmodule

[rtl/dd_ctrl.sv]
module dd_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    last_row,
	output logic                    busy,
	output dd_pkg::dd_cmd_t         cmd,
	input  dd_pkg::dd_status_t      status,
	output logic                    result_valid,
	output logic                    is_verdict,
	output logic [dd_pkg::ID_W-1:0] process_id,
	output logic                    deadlock_free,
	output logic                    last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_VERDICT
	} state_t;

	state_t                  state_q;
	logic                    accept;
	logic                    valid_q;
	logic                    verdict_q;
	logic [dd_pkg::ID_W-1:0] id_q;
	logic                    free_q;
	logic                    last_q;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = state_q != ST_IDLE;

	// commands to the datapath
	assign cmd.load  = accept;
	assign cmd.start = accept && last_row;
	assign cmd.scan  = state_q == ST_SCAN;

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= 1'b0;
			verdict_q <= 1'b0;
			id_q      <= '0;
			free_q    <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && last_row)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (status.hit) begin
						valid_q   <= 1'b1;
						verdict_q <= 1'b0;
						id_q      <= status.id;
						free_q    <= 1'b0;
						last_q    <= 1'b0;
					end
					if (status.last_hit || status.pass_end)
						state_q <= ST_VERDICT;
				end
				ST_VERDICT: begin
					valid_q   <= 1'b1;
					verdict_q <= 1'b1;
					id_q      <= '0;
					free_q    <= status.all_done;
					last_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid  = valid_q;
	assign is_verdict    = verdict_q;
	assign process_id    = id_q;
	assign deadlock_free = free_q;
	assign last          = last_q;

	// a final row always starts a run
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_row) |=> busy)
		else $error("final row did not start a run");

	// the verdict closes the run
	a_verdict_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && verdict_q) |-> (state_q == ST_IDLE))
		else $error("verdict shown while run still active");

	// order entries only come out of an active run
	a_entry_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !verdict_q) |-> busy)
		else $error("order entry outside a run");

	// a scan step never coincides with an accepted row
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !accept)
		else $error("scan overlaps an accepted row");

endmodule

[rtl/deadlock_detection.sv]
// deadlock detection over a table of process rows
//
// input: one process row per item (alloc_res*, req_res*, last_row), taken at
// a clock edge with start high and busy low. rows without last_row just load
// and leave busy low. up to 8 rows are kept; further rows are dropped.
// the row with last_row set starts a run and raises busy until the verdict.
// output: each result is on the result ports for one cycle with result_valid
// high; the receiver cannot stall. a run emits the finished process ids in
// order, then one verdict with is_verdict and last set.
// scan: one compare-and-add unit examines one loaded row per cycle and the scan
// restarts at row 0 after every finished process; an entry shows in the cycle
// after its row is examined, the verdict in the first cycle with busy low again.
// configuration: avail_res0..2 at index 0..2 over cfg_valid/cfg_ready, always
// ready. the user must write them only while idle; the block does not enforce it.
// reset: available vector returns to 7, 8, 6, row count and run state clear.
module deadlock_detection (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [dd_pkg::DATA_W-1:0]    alloc_res0,
	input  logic [dd_pkg::DATA_W-1:0]    alloc_res1,
	input  logic [dd_pkg::DATA_W-1:0]    alloc_res2,
	input  logic [dd_pkg::DATA_W-1:0]    req_res0,
	input  logic [dd_pkg::DATA_W-1:0]    req_res1,
	input  logic [dd_pkg::DATA_W-1:0]    req_res2,
	input  logic                         last_row,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dd_pkg::DATA_W-1:0]    cfg_data,
	output logic                         result_valid,
	output logic                         is_verdict,
	output logic [dd_pkg::ID_W-1:0]      process_id,
	output logic                         deadlock_free,
	output logic                         last
);

	dd_pkg::dd_cmd_t    cmd;
	dd_pkg::dd_status_t status;
	dd_pkg::res_vec_t   row_alloc;
	dd_pkg::res_vec_t   row_req;

	// pack the row fields
	assign row_alloc[0] = alloc_res0;
	assign row_alloc[1] = alloc_res1;
	assign row_alloc[2] = alloc_res2;
	assign row_req[0]   = req_res0;
	assign row_req[1]   = req_res1;
	assign row_req[2]   = req_res2;

	assign cfg_ready = 1'b1;

	dd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last_row      (last_row),
		.busy          (busy),
		.cmd           (cmd),
		.status        (status),
		.result_valid  (result_valid),
		.is_verdict    (is_verdict),
		.process_id    (process_id),
		.deadlock_free (deadlock_free),
		.last          (last)
	);

	dd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.row_alloc (row_alloc),
		.row_req   (row_req),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.status    (status)
	);

endmodule

[tb/deadlock_detection_tb.sv]
module deadlock_detection_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ROWS    = 180;
	localparam int CALM_ROWS      = 30;
	localparam int RUN_CYCLES_MAX =
		(dd_pkg::NUM_PROCESSES + 1) * (dd_pkg::NUM_PROCESSES + 2) / 2 + 1;

	// one process row as it crosses the start handshake
	typedef struct packed {
		dd_pkg::res_vec_t alloc;
		dd_pkg::res_vec_t req;
		logic             last_row;
	} dd_row_t;

	// one entry of the finish order or the verdict
	typedef struct packed {
		logic                    is_verdict;
		logic [dd_pkg::ID_W-1:0] process_id;
		logic                    deadlock_free;
		logic                    last;
	} dd_result_t;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         start         = 1'b0;
	logic                         busy;
	logic [dd_pkg::DATA_W-1:0]    alloc_res0    = '0;
	logic [dd_pkg::DATA_W-1:0]    alloc_res1    = '0;
	logic [dd_pkg::DATA_W-1:0]    alloc_res2    = '0;
	logic [dd_pkg::DATA_W-1:0]    req_res0      = '0;
	logic [dd_pkg::DATA_W-1:0]    req_res1      = '0;
	logic [dd_pkg::DATA_W-1:0]    req_res2      = '0;
	logic                         last_row      = 1'b0;
	logic                         cfg_valid     = 1'b0;
	logic                         cfg_ready;
	logic [dd_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
	logic [dd_pkg::DATA_W-1:0]    cfg_data      = '0;
	logic                         result_valid;
	logic                         is_verdict;
	logic [dd_pkg::ID_W-1:0]      process_id;
	logic                         deadlock_free;
	logic                         last;

	// rows waiting for the driver and results waiting for the monitor
	dd_row_t    pending_rows[$];
	dd_result_t expected_order[$];

	// shadow of the block: loaded rows, available vector, run state
	dd_pkg::res_vec_t                 alloc_rows[dd_pkg::NUM_PROCESSES];
	dd_pkg::res_vec_t                 req_rows[dd_pkg::NUM_PROCESSES];
	dd_pkg::res_vec_t                 avail_now = {dd_pkg::AVAIL_RES2_RST,
		dd_pkg::AVAIL_RES1_RST, dd_pkg::AVAIL_RES0_RST};
	logic [dd_pkg::WORK_W-1:0]        work[dd_pkg::NUM_RESOURCES];
	logic [dd_pkg::NUM_PROCESSES-1:0] done_mask;
	int                               rows_held = 0;

	int  rows_issued   = 0;
	int  rows_accepted = 0;
	int  fail_count    = 0;
	int  verdicts_free = 0;
	int  verdicts_dead = 0;
	int  avail_writes  = 0;
	bit  gaps_on       = 1'b1;
	bit  row_pending   = 1'b0;
	int  gap_left      = 0;
	dd_row_t cur_row;

	deadlock_detection u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.alloc_res0   (alloc_res0),
		.alloc_res1   (alloc_res1),
		.alloc_res2   (alloc_res2),
		.req_res0     (req_res0),
		.req_res1     (req_res1),
		.req_res2     (req_res2),
		.last_row     (last_row),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.is_verdict   (is_verdict),
		.process_id   (process_id),
		.deadlock_free(deadlock_free),
		.last         (last)
	);

	// 12 ns clock
	always #6 clk = ~clk;

	// load one row; a last row runs the detection and queues the order and verdict
	task automatic apply_row(input dd_row_t row);
		int         p;
		int         r;
		int         finished;
		bit         progress;
		bit         fits;
		logic [dd_pkg::WORK_W:0] sum;
		dd_result_t res;
		if (rows_held < dd_pkg::NUM_PROCESSES) begin
			alloc_rows[rows_held] = row.alloc;
			req_rows[rows_held]   = row.req;
			rows_held++;
		end
		if (row.last_row) begin
			for (r = 0; r < dd_pkg::NUM_RESOURCES; r++)
				work[r] = dd_pkg::WORK_W'(avail_now[r]);
			done_mask = '0;
			finished  = 0;
			do begin
				progress = 1'b0;
				for (p = 0; p < rows_held && !progress; p++) begin
					if (!done_mask[p]) begin
						fits = 1'b1;
						for (r = 0; r < dd_pkg::NUM_RESOURCES; r++)
							if (dd_pkg::WORK_W'(req_rows[p][r]) > work[r])
								fits = 1'b0;
						if (fits) begin
							// return the allocation, saturating
							for (r = 0; r < dd_pkg::NUM_RESOURCES; r++) begin
								sum = {1'b0, work[r]}
									+ (dd_pkg::WORK_W + 1)'(alloc_rows[p][r]);
								work[r] = (sum > {1'b0, dd_pkg::WORK_MAX})
									? dd_pkg::WORK_MAX : sum[dd_pkg::WORK_W-1:0];
							end
							done_mask[p] = 1'b1;
							finished++;
							res = '{is_verdict: 1'b0, process_id: dd_pkg::ID_W'(p),
								deadlock_free: 1'b0, last: 1'b0};
							expected_order.push_back(res);
							progress = 1'b1;
						end
					end
				end
			end while (progress && finished < rows_held);
			res = '{is_verdict: 1'b1, process_id: '0,
				deadlock_free: (finished == rows_held), last: 1'b1};
			expected_order.push_back(res);
			rows_held = 0;
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// driver: rows change at the falling edge, start held until the item is taken
	always @(negedge clk) begin : driver
		if (row_pending && rows_accepted == rows_issued)
			row_pending = 1'b0;
		if (arst_n && !row_pending) begin
			if (gap_left == 0 && pending_rows.size() > 0) begin
				cur_row = pending_rows.pop_front();
				{alloc_res2, alloc_res1, alloc_res0} <= cur_row.alloc;
				{req_res2, req_res1, req_res0}       <= cur_row.req;
				last_row    <= cur_row.last_row;
				start       <= 1'b1;
				rows_issued++;
				row_pending = 1'b1;
				if (gaps_on && $urandom_range(0, 2) == 0)
					gap_left = $urandom_range(1, 11);
			end else begin
				// idle: junk on the row ports, start low
				if (gap_left > 0)
					gap_left--;
				{alloc_res2, alloc_res1, alloc_res0} <= 24'($urandom);
				{req_res2, req_res1, req_res0}       <= 24'($urandom);
				last_row <= 1'($urandom);
				start    <= 1'b0;
			end
		end
	end

	// monitor: check results, then record any row taken at this edge
	always @(posedge clk) begin : monitor
		dd_result_t got;
		dd_result_t want;
		dd_row_t    row;
		if (arst_n) begin
			if (result_valid) begin
				got = '{is_verdict: is_verdict, process_id: process_id,
					deadlock_free: deadlock_free, last: last};
				if (expected_order.size() == 0) begin
					$error("unexpected result: is_verdict %0d process_id %0d",
						got.is_verdict, got.process_id);
					fail_count++;
				end else begin
					want = expected_order.pop_front();
					check_field("is_verdict", 8'(want.is_verdict), 8'(got.is_verdict));
					check_field("process_id", 8'(want.process_id), 8'(got.process_id));
					check_field("deadlock_free", 8'(want.deadlock_free),
						8'(got.deadlock_free));
					check_field("last", 8'(want.last), 8'(got.last));
					if (want.is_verdict) begin
						if (want.deadlock_free)
							verdicts_free++;
						else
							verdicts_dead++;
					end
				end
			end
			if (start && !busy) begin
				row.alloc    = {alloc_res2, alloc_res1, alloc_res0};
				row.req      = {req_res2, req_res1, req_res0};
				row.last_row = last_row;
				apply_row(row);
				rows_accepted++;
			end
		end
	end

	task automatic queue_row(input logic [7:0] a0, a1, a2, q0, q1, q2, input logic lr);
		dd_row_t row;
		row.alloc    = {a2, a1, a0};
		row.req      = {q2, q1, q0};
		row.last_row = lr;
		pending_rows.push_back(row);
	endtask

	// wait until every row is taken and every result is in, then let the block settle
	task automatic wait_drained();
		while (!(pending_rows.size() == 0 && rows_accepted == rows_issued &&
			expected_order.size() == 0))
			@(posedge clk);
		repeat (RUN_CYCLES_MAX) @(posedge clk);
	endtask

	task automatic write_avail(input logic [dd_pkg::CFG_IDX_W-1:0] idx,
		input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		avail_now[idx] = val;
		avail_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_avail(input logic [7:0] v0, v1, v2);
		write_avail(dd_pkg::REG_AVAIL_RES0, v0);
		write_avail(dd_pkg::REG_AVAIL_RES1, v1);
		write_avail(dd_pkg::REG_AVAIL_RES2, v2);
	endtask

	function automatic logic [7:0] pick_avail();
		case ($urandom_range(0, 5))
			0: begin
				return 8'd0;
			end
			1: begin
				return 8'd255;
			end
			2, 3: begin
				return 8'($urandom_range(0, 15));
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	// tame rows hold small requests so runs get through several processes
	function automatic dd_row_t random_row(input bit tame, input bit is_last);
		dd_row_t row;
		int      r;
		for (r = 0; r < dd_pkg::NUM_RESOURCES; r++) begin
			if (tame) begin
				row.alloc[r] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, 15));
				row.req[r]   = 8'($urandom_range(0, 12));
			end else begin
				row.alloc[r] = 8'($urandom);
				row.req[r]   = 8'($urandom);
			end
		end
		row.last_row = is_last;
		return row;
	endfunction

	initial begin : stimulus
		int n;
		int k;
		int runs;
		int queued;
		bit tame;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset available vector, a chain where every process finishes
		queue_row(0, 1, 0, 0, 0, 0, 0);
		queue_row(2, 0, 0, 2, 0, 2, 0);
		queue_row(3, 0, 3, 0, 0, 0, 0);
		queue_row(2, 1, 1, 1, 0, 0, 0);
		queue_row(0, 0, 2, 0, 0, 2, 1);
		// lone row that can never fit, lone row holding everything
		queue_row(0, 0, 0, 255, 255, 255, 1);
		queue_row(255, 255, 255, 0, 0, 0, 1);
		// full table with saturating work vector, two dropped rows, last on a dropped row
		queue_row(255, 255, 255, 0, 0, 0, 0);
		for (k = 1; k < dd_pkg::NUM_PROCESSES; k++)
			queue_row(255, 255, 255, 255, 255, 255, 0);
		queue_row(8'($urandom), 8'($urandom), 8'($urandom), 0, 0, 0, 0);
		queue_row(8'($urandom), 8'($urandom), 8'($urandom), 255, 255, 255, 1);
		// request one over and exactly equal to available: order is not row order
		queue_row(0, 0, 0, 8, 8, 6, 0);
		queue_row(1, 0, 0, 7, 8, 6, 1);
		wait_drained();

		// nothing available: a zero request finishes, anything else blocks
		load_avail(8'd0, 8'd0, 8'd0);
		queue_row(0, 0, 0, 0, 0, 0, 0);
		queue_row(0, 0, 0, 0, 1, 0, 1);
		wait_drained();

		// everything available
		load_avail(8'd255, 8'd255, 8'd255);
		queue_row(0, 0, 0, 255, 255, 255, 1);
		wait_drained();

		// random runs, mostly well-formed tables, new available vector every few runs
		runs   = 0;
		queued = 0;
		while (queued < RANDOM_ROWS) begin
			if (gaps_on && queued >= RANDOM_ROWS - CALM_ROWS) begin
				wait_drained();
				gaps_on = 1'b0;
			end
			if (runs % 6 == 0) begin
				wait_drained();
				load_avail(pick_avail(), pick_avail(), pick_avail());
			end
			n    = ($urandom_range(0, 9) == 0)
				? $urandom_range(dd_pkg::NUM_PROCESSES + 1, dd_pkg::NUM_PROCESSES + 3)
				: $urandom_range(1, dd_pkg::NUM_PROCESSES);
			tame = ($urandom_range(0, 3) != 0);
			for (k = 0; k < n; k++)
				pending_rows.push_back(random_row(tame, k == n - 1));
			queued += n;
			runs++;
		end
		wait_drained();

		if (expected_order.size() != 0) begin
			$error("%0d results never arrived", expected_order.size());
			fail_count++;
		end
		$display("%0d process rows loaded, %0d runs ended deadlock-free, %0d deadlocked",
			rows_accepted, verdicts_free, verdicts_dead);
		$display("%0d available-vector writes, tables up to %0d rows plus dropped rows",
			avail_writes, dd_pkg::NUM_PROCESSES);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run limit
	initial begin : watchdog
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/dd_pkg.sv
rtl/dd_datapath.sv
rtl/dd_ctrl.sv
rtl/deadlock_detection.sv
tb/deadlock_detection_tb.sv
